/* hw/rtl/hrsp_pkg.sv */
// ============================================================================
// hrsp_pkg: shared definitions for the HTTP request stream parser
// Phase codes, result kinds, error codes, character constants and helpers.
// ============================================================================
package hrsp_pkg;

    localparam int LEN_BITS_DEF = 12;
    localparam int CFG_W        = 12;
    localparam int METHOD_MAX   = 10;
    localparam int METHOD_LEN_W = 5;
    localparam int METHOD_KEEP  = 6;
    localparam int VER_LEN      = 8;

    localparam logic [CFG_W-1:0] ROUTE_MAX_RST = 12'd99;
    localparam logic [CFG_W-1:0] LINE_MAX_RST  = 12'd4095;

    localparam logic [0:0] CFG_IDX_ROUTE = 1'b0;
    localparam logic [0:0] CFG_IDX_LINE  = 1'b1;

    localparam logic [2:0] PH_SKIP    = 3'd0;
    localparam logic [2:0] PH_METHOD  = 3'd1;
    localparam logic [2:0] PH_ROUTE   = 3'd2;
    localparam logic [2:0] PH_VERSION = 3'd3;
    localparam logic [2:0] PH_VERLF   = 3'd4;
    localparam logic [2:0] PH_HEADER  = 3'd5;
    localparam logic [2:0] PH_BODY    = 3'd6;
    localparam logic [2:0] PH_ERROR   = 3'd7;

    localparam logic [2:0] KIND_METHOD = 3'd0;
    localparam logic [2:0] KIND_ROUTE  = 3'd1;
    localparam logic [2:0] KIND_NAME   = 3'd2;
    localparam logic [2:0] KIND_VALUE  = 3'd3;
    localparam logic [2:0] KIND_HDR    = 3'd4;
    localparam logic [2:0] KIND_BODY   = 3'd5;
    localparam logic [2:0] KIND_END    = 3'd6;
    localparam logic [2:0] KIND_ERROR  = 3'd7;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_METHOD    = 3'd1;
    localparam logic [2:0] ERR_ROUTE     = 3'd2;
    localparam logic [2:0] ERR_VERSION   = 3'd3;
    localparam logic [2:0] ERR_LINE      = 3'd4;

    localparam logic [1:0] MC_GET     = 2'd0;
    localparam logic [1:0] MC_POST    = 2'd1;
    localparam logic [1:0] MC_DELETE  = 2'd2;
    localparam logic [1:0] MC_UNKNOWN = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // first byte in the low byte
    localparam logic [47:0] WORD_GET    = 48'h0000_0054_4547;
    localparam logic [47:0] WORD_POST   = 48'h0000_5453_4F50;
    localparam logic [47:0] WORD_DELETE = 48'h4554_454C_4544;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] ch;
        logic [1:0] mc;
        logic       hv;
        logic [2:0] ec;
        logic       eor;
    } res_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // "HTTP/1.1"
    function automatic logic [7:0] version_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h48;
            3'd1:    ch = 8'h54;
            3'd2:    ch = 8'h54;
            3'd3:    ch = 8'h50;
            3'd4:    ch = 8'h2F;
            3'd5:    ch = 8'h31;
            3'd6:    ch = 8'h2E;
            3'd7:    ch = 8'h31;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [1:0] method_of(input logic [METHOD_LEN_W-1:0] len,
                                             input logic [47:0] chars);
        logic [1:0] mc;
        mc = MC_UNKNOWN;
        if (len == METHOD_LEN_W'(3) && chars == WORD_GET)
            mc = MC_GET;
        else if (len == METHOD_LEN_W'(4) && chars == WORD_POST)
            mc = MC_POST;
        else if (len == METHOD_LEN_W'(6) && chars == WORD_DELETE)
            mc = MC_DELETE;
        return mc;
    endfunction

endpackage

/* hw/rtl/http_request_stream_parser.sv */
// The results of an accepted byte are registered in the result queue before they are offered.
// Throughput: one byte per cycle while results drain; a byte with two results needs
// two output beats, and s_axis_tready drops while the 4-entry result queue has
// fewer than two free entries.
// Reset (rst_n low, asynchronous): parser back to whitespace skip, route limit 99,
// line limit 4095, result queue empty.
// ============================================================================
// http_request_stream_parser
// Byte-serial HTTP/1.1 request parser: method, route, version, header lines
// and body, with coded errors, emitted as typed result beats.
// ============================================================================
module http_request_stream_parser #(
    parameter int LEN_BITS = hrsp_pkg::LEN_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [hrsp_pkg::CFG_W-1:0] cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // data_byte
    input  logic                       s_axis_tlast,   // last_byte
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [15:0]                m_axis_tdata,   // char_out, method_code,
                                                       // header_valid, error_code, 0 pad
    output logic [2:0]                 m_axis_tuser,   // item_kind
    output logic                       m_axis_tlast    // end_of_run
);

    localparam int CMP_W = (LEN_BITS > hrsp_pkg::CFG_W) ? LEN_BITS : hrsp_pkg::CFG_W;

    // configuration
    logic [hrsp_pkg::CFG_W-1:0] route_max_reg;
    logic [hrsp_pkg::CFG_W-1:0] line_max_reg;

    // parser state
    logic [2:0]          phase_reg,      phase_next;
    logic [LEN_BITS-1:0] field_len_reg,  field_len_next;
    logic [47:0]         method_chars_reg, method_chars_next;
    logic [3:0]          ver_idx_reg,    ver_idx_next;
    logic                ver_ok_reg,     ver_ok_next;
    logic                pending_cr_reg, pending_cr_next;
    logic                colon_reg,      colon_next;
    logic                skip_sp_reg,    skip_sp_next;
    logic                named_reg,      named_next;

    // result queue
    hrsp_pkg::res_t fifo_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;

    logic           in_acc;
    logic           out_acc;
    logic [7:0]     c;
    logic [LEN_BITS-1:0] fl_base;
    logic [LEN_BITS-1:0] fl1;
    logic [47:0]    mc_base;
    logic           p_valid;
    hrsp_pkg::res_t p_res;
    logic           hdr_err;
    hrsp_pkg::res_t r0;
    hrsp_pkg::res_t r1;
    logic [1:0]     n_push;

    assign c       = s_axis_tdata;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_max_reg <= hrsp_pkg::ROUTE_MAX_RST;
            line_max_reg  <= hrsp_pkg::LINE_MAX_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == hrsp_pkg::CFG_IDX_ROUTE)
                route_max_reg <= cfg_data;
            else
                line_max_reg <= cfg_data;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        field_len_next    = field_len_reg;
        method_chars_next = method_chars_reg;
        ver_idx_next      = ver_idx_reg;
        ver_ok_next       = ver_ok_reg;
        pending_cr_next   = pending_cr_reg;
        colon_next        = colon_reg;
        skip_sp_next      = skip_sp_reg;
        named_next        = named_reg;
        p_valid           = 1'b0;
        p_res             = '0;
        hdr_err           = 1'b0;
        fl_base           = field_len_reg;
        fl1               = field_len_reg;
        mc_base           = method_chars_reg;

        case (phase_reg)
            hrsp_pkg::PH_SKIP, hrsp_pkg::PH_METHOD:
            begin
                if (!(phase_reg == hrsp_pkg::PH_SKIP && hrsp_pkg::is_ws(c)))
                begin
                    if (phase_reg == hrsp_pkg::PH_SKIP)
                    begin
                        fl_base = '0;
                        mc_base = '0;
                    end
                    method_chars_next = mc_base;
                    if (c == hrsp_pkg::CH_SPACE)
                    begin
                        p_valid        = 1'b1;
                        p_res.kind     = hrsp_pkg::KIND_METHOD;
                        p_res.mc       = hrsp_pkg::method_of(
                                             fl_base[hrsp_pkg::METHOD_LEN_W-1:0], mc_base);
                        phase_next     = hrsp_pkg::PH_ROUTE;
                        field_len_next = '0;
                    end
                    else if (fl_base >= LEN_BITS'(hrsp_pkg::METHOD_MAX))
                    begin
                        p_valid    = 1'b1;
                        p_res.kind = hrsp_pkg::KIND_ERROR;
                        p_res.ec   = hrsp_pkg::ERR_METHOD;
                        phase_next = hrsp_pkg::PH_ERROR;
                    end
                    else
                    begin
                        if (fl_base < LEN_BITS'(hrsp_pkg::METHOD_KEEP))
                        begin
                            for (int i = 0; i < hrsp_pkg::METHOD_KEEP; i++)
                            begin
                                if (fl_base[2:0] == 3'(i))
                                    method_chars_next[8*i +: 8] = c;
                            end
                        end
                        field_len_next = fl_base + LEN_BITS'(1);
                        phase_next     = hrsp_pkg::PH_METHOD;
                    end
                end
            end
            hrsp_pkg::PH_ROUTE:
            begin
                if (c == hrsp_pkg::CH_SPACE)
                begin
                    phase_next     = hrsp_pkg::PH_VERSION;
                    field_len_next = '0;
                end
                else if (CMP_W'(field_len_reg) >= CMP_W'(route_max_reg))
                begin
                    p_valid    = 1'b1;
                    p_res.kind = hrsp_pkg::KIND_ERROR;
                    p_res.ec   = hrsp_pkg::ERR_ROUTE;
                    phase_next = hrsp_pkg::PH_ERROR;
                end
                else
                begin
                    field_len_next = field_len_reg + LEN_BITS'(1);
                    p_valid        = 1'b1;
                    p_res.kind     = hrsp_pkg::KIND_ROUTE;
                    p_res.ch       = c;
                end
            end
            hrsp_pkg::PH_VERSION:
            begin
                if (c == hrsp_pkg::CH_CR)
                begin
                    if (!ver_ok_reg || ver_idx_reg != 4'(hrsp_pkg::VER_LEN))
                    begin
                        p_valid    = 1'b1;
                        p_res.kind = hrsp_pkg::KIND_ERROR;
                        p_res.ec   = hrsp_pkg::ERR_VERSION;
                        phase_next = hrsp_pkg::PH_ERROR;
                    end
                    else
                    begin
                        phase_next     = hrsp_pkg::PH_VERLF;
                        field_len_next = '0;
                    end
                end
                else if (ver_ok_reg && !ver_idx_reg[3]
                         && c == hrsp_pkg::version_char(ver_idx_reg[2:0]))
                    ver_idx_next = ver_idx_reg + 4'd1;
                else
                    ver_ok_next = 1'b0;
            end
            hrsp_pkg::PH_VERLF, hrsp_pkg::PH_HEADER:
            begin
                phase_next = hrsp_pkg::PH_HEADER;
                if (!(phase_reg == hrsp_pkg::PH_VERLF && c == hrsp_pkg::CH_LF))
                begin
                    if (pending_cr_reg && c == hrsp_pkg::CH_LF)
                    begin
                        pending_cr_next = 1'b0;
                        if (field_len_reg == '0)
                            phase_next = hrsp_pkg::PH_BODY;
                        else
                        begin
                            p_valid        = 1'b1;
                            p_res.kind     = hrsp_pkg::KIND_HDR;
                            p_res.hv       = colon_reg && named_reg;
                            field_len_next = '0;
                            colon_next     = 1'b0;
                            skip_sp_next   = 1'b0;
                            named_next     = 1'b0;
                        end
                    end
                    else
                    begin
                        // a lone CR counts as a line byte
                        if (pending_cr_reg)
                        begin
                            pending_cr_next = 1'b0;
                            if (CMP_W'(field_len_reg) >= CMP_W'(line_max_reg))
                                hdr_err = 1'b1;
                            else
                                fl1 = field_len_reg + LEN_BITS'(1);
                        end
                        if (!hdr_err)
                        begin
                            if (c == hrsp_pkg::CH_CR)
                            begin
                                pending_cr_next = 1'b1;
                                field_len_next  = fl1;
                            end
                            else if (CMP_W'(fl1) >= CMP_W'(line_max_reg))
                                hdr_err = 1'b1;
                            else
                            begin
                                field_len_next = fl1 + LEN_BITS'(1);
                                if (!colon_reg)
                                begin
                                    if (c == hrsp_pkg::CH_COLON)
                                    begin
                                        colon_next   = 1'b1;
                                        skip_sp_next = 1'b1;
                                    end
                                    else
                                    begin
                                        named_next = 1'b1;
                                        p_valid    = 1'b1;
                                        p_res.kind = hrsp_pkg::KIND_NAME;
                                        p_res.ch   = c;
                                    end
                                end
                                else if (!(skip_sp_reg && hrsp_pkg::is_ws(c)))
                                begin
                                    skip_sp_next = 1'b0;
                                    p_valid      = 1'b1;
                                    p_res.kind   = hrsp_pkg::KIND_VALUE;
                                    p_res.ch     = c;
                                end
                            end
                        end
                        if (hdr_err)
                        begin
                            p_valid    = 1'b1;
                            p_res.kind = hrsp_pkg::KIND_ERROR;
                            p_res.ec   = hrsp_pkg::ERR_LINE;
                            phase_next = hrsp_pkg::PH_ERROR;
                        end
                    end
                end
            end
            hrsp_pkg::PH_BODY:
            begin
                p_valid    = 1'b1;
                p_res.kind = hrsp_pkg::KIND_BODY;
                p_res.ch   = c;
            end
            default:
            begin
                p_valid = 1'b0;
            end
        endcase

        if (s_axis_tlast)
        begin
            phase_next        = hrsp_pkg::PH_SKIP;
            field_len_next    = '0;
            method_chars_next = '0;
            ver_idx_next      = '0;
            ver_ok_next       = 1'b1;
            pending_cr_next   = 1'b0;
            colon_next        = 1'b0;
            skip_sp_next      = 1'b0;
            named_next        = 1'b0;
        end

        // assemble the beats of this byte
        r0      = p_res;
        r1      = '0;
        r1.kind = hrsp_pkg::KIND_END;
        r1.eor  = 1'b1;
        n_push  = 2'd0;
        if (p_valid && s_axis_tlast)
            n_push = 2'd2;
        else if (p_valid)
        begin
            r0.eor = 1'b1;
            n_push = 2'd1;
        end
        else if (s_axis_tlast)
        begin
            r0     = r1;
            n_push = 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= hrsp_pkg::PH_SKIP;
            field_len_reg    <= '0;
            method_chars_reg <= '0;
            ver_idx_reg      <= '0;
            ver_ok_reg       <= 1'b1;
            pending_cr_reg   <= 1'b0;
            colon_reg        <= 1'b0;
            skip_sp_reg      <= 1'b0;
            named_reg        <= 1'b0;
        end
        else if (in_acc)
        begin
            phase_reg        <= phase_next;
            field_len_reg    <= field_len_next;
            method_chars_reg <= method_chars_next;
            ver_idx_reg      <= ver_idx_next;
            ver_ok_reg       <= ver_ok_next;
            pending_cr_reg   <= pending_cr_next;
            colon_reg        <= colon_next;
            skip_sp_reg      <= skip_sp_next;
            named_reg        <= named_next;
        end
    end

    // result queue
    always_ff @(posedge clk)
    begin
        if (in_acc && n_push != 2'd0)
            fifo_reg[wr_ptr_reg] <= r0;
        if (in_acc && n_push == 2'd2)
            fifo_reg[wr_ptr_reg + 2'd1] <= r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_acc)
                wr_ptr_reg <= wr_ptr_reg + n_push;
            if (out_acc)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + (in_acc ? {1'b0, n_push} : 3'd0)
                         - (out_acc ? 3'd1 : 3'd0);
        end
    end

    assign s_axis_tready = (count_reg <= 3'd2);
    assign m_axis_tvalid = (count_reg != 3'd0);
    assign m_axis_tdata  = {2'b00, fifo_reg[rd_ptr_reg].ec, fifo_reg[rd_ptr_reg].hv,
                            fifo_reg[rd_ptr_reg].mc, fifo_reg[rd_ptr_reg].ch};
    assign m_axis_tuser  = fifo_reg[rd_ptr_reg].kind;
    assign m_axis_tlast  = fifo_reg[rd_ptr_reg].eor;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("result queue overflow");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_axis_tlast) |=> (phase_reg == hrsp_pkg::PH_SKIP))
        else $error("parser not back in whitespace skip after last byte");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == hrsp_pkg::PH_ERROR && !(in_acc && s_axis_tlast))
        |=> (phase_reg == hrsp_pkg::PH_ERROR))
        else $error("error phase left before last byte");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == hrsp_pkg::KIND_END) |-> m_axis_tlast)
        else $error("request end beat without tlast");
`endif

endmodule

/* test/testbench.sv */
// ============================================================================
// testbench: self-checking bench for http_request_stream_parser
//
// A driver feeds request bytes from a queue and predicts each byte's
// result beats. A monitor compares every output beat with the oldest
// prediction. The bench drives a short directed set and then random
// requests, mostly well formed with random content and the rest noise.
// These run under several route and line limits with random idling on
// both sides, one long output stall, and a drain before each limit change.
// ============================================================================
module testbench;

    import hrsp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_BYTES = 300;
    localparam int HOLD_CYCLES = 150;
    localparam logic [63:0] VERSION_TEXT = "HTTP/1.1";

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } req_beat_t;

    typedef enum {CLS_NAME, CLS_VALUE, CLS_ROUTE, CLS_UPPER, CLS_BLANK, CLS_BODY} char_class_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [0:0]           cfg_index = CFG_IDX_ROUTE;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;    // data_byte
    logic                 s_axis_tlast = 1'b0;  // last_byte
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;         // char_out, method_code, header_valid,
                                                // error_code, 0 pad
    logic [2:0]           m_axis_tuser;         // item_kind
    logic                 m_axis_tlast;         // end_of_run

    // parser model state
    logic [2:0]           pstate;
    int                   seg_len;
    logic [47:0]          meth_word;
    int                   ver_idx;
    bit                   ver_good;
    bit                   cr_pending;
    bit                   colon_hit;
    bit                   skip_value_ws;
    bit                   halted;
    bit                   name_nonempty;
    logic [CFG_W-1:0]     route_limit = ROUTE_MAX_RST;
    logic [CFG_W-1:0]     line_limit = LINE_MAX_RST;

    res_t                 step_out[$];
    res_t                 expected_results[$];
    req_beat_t            pending_beats[$];
    logic [7:0]           req_text[$];

    req_beat_t            beat_out;
    res_t                 want;
    int                   send_gap = 0;
    int                   recv_gap = 0;
    bit                   sender_calm = 1'b0;
    bit                   receiver_calm = 1'b0;
    bit                   hold_go = 1'b0;
    logic                 recv_hold = 1'b0;

    int                   cycle_count = 0;
    int                   mismatches = 0;
    int                   beats_queued = 0;
    int                   beats_sent = 0;
    int                   requests_queued = 0;
    int                   results_seen = 0;
    int                   errors_seen = 0;
    int                   headers_seen = 0;
    int                   settings_run = 1;

    http_request_stream_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------------
    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    task automatic clear_parser();
        pstate = PH_SKIP;
        seg_len = 0;
        meth_word = '0;
        ver_idx = 0;
        ver_good = 1'b1;
        cr_pending = 1'b0;
        colon_hit = 1'b0;
        skip_value_ws = 1'b0;
        halted = 1'b0;
        name_nonempty = 1'b0;
    endtask

    task automatic emit(input logic [2:0] k, input logic [7:0] ch, input logic [1:0] mc,
                        input logic hv, input logic [2:0] ec);
        res_t r;
        r.kind = k;
        r.ch = ch;
        r.mc = mc;
        r.hv = hv;
        r.ec = ec;
        r.eor = 1'b0;
        step_out.push_back(r);
    endtask

    task automatic flag_error(input logic [2:0] code);
        pstate = PH_ERROR;
        halted = 1'b1;
        emit(KIND_ERROR, 8'h00, '0, 1'b0, code);
    endtask

    task automatic predict_header_byte(input logic [7:0] c);
        bit over;
        over = 1'b0;
        if (cr_pending && c == CH_LF)
        begin
            cr_pending = 1'b0;
            if (seg_len == 0)
                pstate = PH_BODY;
            else
            begin
                emit(KIND_HDR, 8'h00, '0, colon_hit && name_nonempty, ERR_NONE);
                seg_len = 0;
                colon_hit = 1'b0;
                skip_value_ws = 1'b0;
                name_nonempty = 1'b0;
            end
        end
        else
        begin
            // lone CR counts toward the line length
            if (cr_pending)
            begin
                cr_pending = 1'b0;
                if (seg_len >= line_limit)
                    over = 1'b1;
                else
                    seg_len++;
            end
            if (over)
                flag_error(ERR_LINE);
            else if (c == CH_CR)
                cr_pending = 1'b1;
            else if (seg_len >= line_limit)
                flag_error(ERR_LINE);
            else
            begin
                seg_len++;
                if (!colon_hit)
                begin
                    if (c == CH_COLON)
                    begin
                        colon_hit = 1'b1;
                        skip_value_ws = 1'b1;
                    end
                    else
                    begin
                        name_nonempty = 1'b1;
                        emit(KIND_NAME, c, '0, 1'b0, ERR_NONE);
                    end
                end
                else if (!(skip_value_ws && is_blank(c)))
                begin
                    skip_value_ws = 1'b0;
                    emit(KIND_VALUE, c, '0, 1'b0, ERR_NONE);
                end
            end
        end
    endtask

    task automatic predict_byte(input logic [7:0] c, input logic last);
        logic [1:0] mc;
        res_t       r;
        step_out.delete();
        if (!halted)
        begin
            if (pstate == PH_SKIP && !is_blank(c))
            begin
                pstate = PH_METHOD;
                seg_len = 0;
                meth_word = '0;
            end
            case (pstate)
                PH_METHOD:
                begin
                    if (c == CH_SPACE)
                    begin
                        if (seg_len == 3 && meth_word == WORD_GET)
                            mc = MC_GET;
                        else if (seg_len == 4 && meth_word == WORD_POST)
                            mc = MC_POST;
                        else if (seg_len == 6 && meth_word == WORD_DELETE)
                            mc = MC_DELETE;
                        else
                            mc = MC_UNKNOWN;
                        emit(KIND_METHOD, 8'h00, mc, 1'b0, ERR_NONE);
                        pstate = PH_ROUTE;
                        seg_len = 0;
                    end
                    else if (seg_len >= METHOD_MAX)
                        flag_error(ERR_METHOD);
                    else
                    begin
                        if (seg_len < METHOD_KEEP)
                            meth_word[8*seg_len +: 8] = c;
                        seg_len++;
                    end
                end
                PH_ROUTE:
                begin
                    if (c == CH_SPACE)
                    begin
                        pstate = PH_VERSION;
                        seg_len = 0;
                    end
                    else if (seg_len >= route_limit)
                        flag_error(ERR_ROUTE);
                    else
                    begin
                        seg_len++;
                        emit(KIND_ROUTE, c, '0, 1'b0, ERR_NONE);
                    end
                end
                PH_VERSION:
                begin
                    if (c == CH_CR)
                    begin
                        if (!ver_good || ver_idx != VER_LEN)
                            flag_error(ERR_VERSION);
                        else
                        begin
                            pstate = PH_VERLF;
                            seg_len = 0;
                        end
                    end
                    else if (ver_good && ver_idx < VER_LEN &&
                             c == VERSION_TEXT[63 - 8*ver_idx -: 8])
                        ver_idx++;
                    else
                        ver_good = 1'b0;
                end
                PH_VERLF:
                begin
                    pstate = PH_HEADER;
                    if (c != CH_LF)
                        predict_header_byte(c);
                end
                PH_HEADER:
                    predict_header_byte(c);
                PH_BODY:
                    emit(KIND_BODY, c, '0, 1'b0, ERR_NONE);
                default:
                    ;
            endcase
        end
        if (last)
        begin
            emit(KIND_END, 8'h00, '0, 1'b0, ERR_NONE);
            clear_parser();
        end
        foreach (step_out[i])
        begin
            r = step_out[i];
            r.eor = (i == step_out.size() - 1);
            expected_results.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tlast <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_byte(s_axis_tdata, s_axis_tlast);
                beats_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    beat_out = pending_beats.pop_front();
                    s_axis_tdata <= beat_out.data;
                    s_axis_tlast <= beat_out.last;
                    s_axis_tvalid <= 1'b1;
                    send_gap = sender_calm ? 0 : $urandom_range(0, 3);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            $error("%s expected %0d actual %0d", name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected, item_kind %0d", m_axis_tuser);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("item_kind", want.kind, m_axis_tuser);
                    check_field("char_out", want.ch, m_axis_tdata[7:0]);
                    check_field("method_code", want.mc, m_axis_tdata[9:8]);
                    check_field("header_valid", want.hv, m_axis_tdata[10]);
                    check_field("error_code", want.ec, m_axis_tdata[13:11]);
                    check_field("end_of_run", want.eor, m_axis_tlast);
                    if (want.kind == KIND_ERROR)
                        errors_seen++;
                    if (want.kind == KIND_HDR)
                        headers_seen++;
                end
                recv_gap = receiver_calm ? 0 : $urandom_range(0, 3);
            end
            if (recv_hold || recv_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                if (recv_gap > 0)
                    recv_gap--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // long output stall while the sender keeps offering bytes
    initial
    begin
        while (!hold_go)
            @(negedge clk);
        @(posedge clk);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    function automatic logic [7:0] token_char(input char_class_t cls);
        logic [7:0] c;
        case (cls)
            CLS_NAME:
            begin
                do
                    c = 8'($urandom_range(8'h21, 8'h7E));
                while (c == CH_COLON);
            end
            CLS_VALUE:
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == CH_CR);
                end
                else
                    c = 8'($urandom_range(8'h20, 8'h7E));
            end
            CLS_ROUTE:
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == CH_SPACE);
                end
                else
                    c = 8'($urandom_range(8'h21, 8'h7E));
            end
            CLS_UPPER:
                c = 8'($urandom_range(8'h41, 8'h5A));
            CLS_BLANK:
                c = ($urandom_range(0, 5) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
            default:
                c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            req_text.push_back(s[i]);
    endtask

    task automatic add_chars(input char_class_t cls, input int n);
        repeat (n) req_text.push_back(token_char(cls));
    endtask

    task automatic commit_request();
        req_beat_t b;
        foreach (req_text[i])
        begin
            b.data = req_text[i];
            b.last = (i == req_text.size() - 1);
            pending_beats.push_back(b);
            beats_queued++;
        end
        requests_queued++;
        req_text.delete();
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] route_max, input logic [CFG_W-1:0] line_max,
                             input bit snd_calm, input bit rcv_calm, input bit with_hold);
        int    target;
        int    style;
        string v;
        wait_drained();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_IDX_ROUTE;
        cfg_data <= route_max;
        @(posedge clk);
        cfg_index <= CFG_IDX_LINE;
        cfg_data <= line_max;
        @(posedge clk);
        cfg_we <= 1'b0;
        route_limit = route_max;
        line_limit = line_max;
        settings_run++;
        @(negedge clk);
        sender_calm = snd_calm;
        receiver_calm = rcv_calm;
        target = beats_queued + PHASE_BYTES;
        while (beats_queued < target)
        begin
            req_text.delete();
            if ($urandom_range(0, 7) == 0)
                add_chars(CLS_BODY, $urandom_range(1, 16));
            else
            begin
                add_chars(CLS_BLANK, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
                case ($urandom_range(0, 4))
                    0: add_text("GET");
                    1: add_text("POST");
                    2: add_text("DELETE");
                    3: add_chars(CLS_UPPER, $urandom_range(1, 12));
                    default:
                    begin
                        add_text("POST");
                        add_chars(CLS_UPPER, $urandom_range(0, 7));
                    end
                endcase
                req_text.push_back(CH_SPACE);
                add_chars(CLS_ROUTE, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 48)
                                                                   : $urandom_range(0, 10));
                req_text.push_back(CH_SPACE);
                v = "HTTP/1.1";
                case ($urandom_range(0, 11))
                    0: v.putc($urandom_range(0, 7), token_char(CLS_NAME));
                    1: v = v.substr(0, $urandom_range(0, 6));
                    2: v = {v, "1"};
                    default: ;
                endcase
                add_text(v);
                req_text.push_back(CH_CR);
                if ($urandom_range(0, 9) != 0)
                    req_text.push_back(CH_LF);
                repeat ($urandom_range(0, 3))
                begin
                    // 0: no colon, 1: empty name, 2: lone CR, 3: bare LF
                    style = $urandom_range(0, 9);
                    if (style != 1)
                        add_chars(CLS_NAME, $urandom_range(1, 6));
                    if (style != 0)
                    begin
                        req_text.push_back(CH_COLON);
                        repeat ($urandom_range(0, 2))
                            req_text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                        add_chars(CLS_VALUE, $urandom_range(0, 8));
                    end
                    if (style == 2)
                    begin
                        req_text.push_back(CH_CR);
                        req_text.push_back(token_char(CLS_NAME));
                    end
                    if (style == 3)
                    begin
                        req_text.push_back(CH_LF);
                        add_chars(CLS_VALUE, $urandom_range(0, 3));
                    end
                    req_text.push_back(CH_CR);
                    req_text.push_back(CH_LF);
                end
                req_text.push_back(CH_CR);
                req_text.push_back(CH_LF);
                add_chars(CLS_BODY, $urandom_range(0, 8));
                if ($urandom_range(0, 9) == 0)
                    req_text = req_text[0:$urandom_range(0, req_text.size() - 1)];
            end
            commit_request();
        end
        if (with_hold)
            hold_go = 1'b1;
    endtask

    initial
    begin
        clear_parser();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset limits: whitespace skip, DELETE, extreme route byte, bad version
        req_text.push_back(CH_CR);
        add_text("DELETE /");
        req_text.push_back(8'hFF);
        add_text(" HTTP/1.0");
        req_text.push_back(CH_CR);
        commit_request();
        req_text.push_back(8'h00);
        commit_request();
        // method beat and request end from one byte
        add_text("GET ");
        commit_request();

        run_phase(12'd40, 12'd4095, 1'b1, 1'b1, 1'b0);
        run_phase(12'd1, 12'd1, 1'b0, 1'b0, 1'b0);
        run_phase(12'd4095, 12'd4095, 1'b1, 1'b0, 1'b1);
        run_phase(12'd8, 12'd12, 1'b0, 1'b0, 1'b0);
        run_phase(CFG_W'($urandom_range(2, 20)), CFG_W'($urandom_range(4, 24)),
                  1'b0, 1'b1, 1'b0);
        wait_drained();

        $display("Sent %0d bytes in %0d requests under %0d limit settings.",
                 beats_sent, requests_queued, settings_run);
        $display("Checked %0d result beats: %0d header ends, %0d parse errors.",
                 results_seen, headers_seen, errors_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/hrsp_pkg.sv
hw/rtl/http_request_stream_parser.sv
test/testbench.sv
